// ----- design/kts_pkg.sv -----
package kts_pkg;

  localparam int NUM_TABLES     = 3;
  localparam int TABLE_DEPTH    = 256;
  localparam int CAPS_LOCK_CODE = 57;

  localparam int CFG_TABLES  = 3;
  localparam int STORE_DEPTH = NUM_TABLES * TABLE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LIM_W       = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int ADB_LIMIT   = 128;

  localparam logic [7:0] KEY_UNMAPPED = 8'hff;
  localparam logic [6:0] CODE_MASK    = 7'h7f;
  localparam logic [7:0] RELEASE_BIT  = 8'h80;
  localparam logic [6:0] CAPS_CODE    = 7'(CAPS_LOCK_CODE) & CODE_MASK;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_REMAP = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WINDOW   = 2'd1,
    ST_ADB      = 2'd2,
    ST_UNMAPPED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T0_MIN = 3'd0,
    REG_T0_MAX = 3'd1,
    REG_T1_MIN = 3'd2,
    REG_T1_MAX = 3'd3,
    REG_T2_MIN = 3'd4,
    REG_T2_MAX = 3'd5,
    REG_LINUX  = 3'd6,
    REG_OSX    = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EVAL
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic load_step;
    logic fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_load;
    logic load_last;
    logic out_free;
  } ctrl_sts_t;

  localparam logic [7:0] DEFAULT_ROM [128] = '{
    8'hff, 8'd53, 8'd18, 8'd19, 8'd20, 8'd21, 8'd23, 8'd22, 8'd26, 8'd28,
    8'd25, 8'd29, 8'd27, 8'd24, 8'd51, 8'd48, 8'd12, 8'd13, 8'd14, 8'd15,
    8'd17, 8'd16, 8'd32, 8'd34, 8'd31, 8'd35, 8'd33, 8'd30, 8'd36, 8'd54,
    8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd4, 8'd38, 8'd40, 8'd37, 8'd41,
    8'd39, 8'd50, 8'd56, 8'd42, 8'd6, 8'd7, 8'd8, 8'd9, 8'd11, 8'd45,
    8'd46, 8'd43, 8'd47, 8'd44, 8'd123, 8'd67, 8'd58, 8'd49, 8'd57, 8'd122,
    8'd120, 8'd99, 8'd118, 8'd96, 8'd97, 8'd98, 8'd100, 8'd101, 8'd109, 8'd71,
    8'd107, 8'd89, 8'd91, 8'd92, 8'd78, 8'd86, 8'd87, 8'd88, 8'd69, 8'd83,
    8'd84, 8'd85, 8'd82, 8'd65, 8'hff, 8'd105, 8'd50, 8'd103, 8'd111, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'd76, 8'd54, 8'd75, 8'd105,
    8'd58, 8'hff, 8'd115, 8'd62, 8'd116, 8'd59, 8'd60, 8'd119, 8'd61, 8'd121,
    8'd114, 8'd117, 8'hff, 8'hff, 8'hff, 8'd107, 8'hff, 8'd81, 8'hff, 8'd113,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'd55, 8'd55, 8'hff
  };

endpackage

// ----- design/kts_ram.sv -----
module kts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/kts_ctrl.sv -----
module kts_ctrl
  import kts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = sts_i.go_load ? S_LOAD : S_EVAL;
        end
      end
      S_LOAD: begin
        if (sts_i.load_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.capture  = s_tvalid_i;
      end
      S_LOAD: cmd_o.load_step = 1'b1;
      S_EVAL: cmd_o.fire = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- design/kts_datapath.sv -----
module kts_datapath
  import kts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic [23:0]          s_tdata_i,
  input  logic [3:0]           s_tuser_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [15:0]          m_tdata_o,
  output logic [2:0]           m_tuser_o,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o
);

  // configuration
  logic [7:0] win_min_q [CFG_TABLES];
  logic [7:0] win_max_q [CFG_TABLES];
  logic       linux_q, osx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_TABLES; i++) begin
        win_min_q[i] <= 8'd0;
        win_max_q[i] <= 8'd127;
      end
      linux_q <= 1'b1;
      osx_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_T0_MIN: win_min_q[0] <= cfg_wdata_i;
        REG_T0_MAX: win_max_q[0] <= cfg_wdata_i;
        REG_T1_MIN: win_min_q[1] <= cfg_wdata_i;
        REG_T1_MAX: win_max_q[1] <= cfg_wdata_i;
        REG_T2_MIN: win_min_q[2] <= cfg_wdata_i;
        REG_T2_MAX: win_max_q[2] <= cfg_wdata_i;
        REG_LINUX:  linux_q      <= cfg_wdata_i[0];
        REG_OSX:    osx_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input fields
  op_e        in_op;
  logic [1:0] in_tsel;
  logic [7:0] in_kc;
  logic       in_press;
  logic [7:0] in_adb;

  assign in_op    = op_e'(s_tuser_i[1:0]);
  assign in_tsel  = s_tuser_i[3:2];
  assign in_kc    = s_tdata_i[7:0];
  assign in_press = s_tdata_i[8];
  assign in_adb   = s_tdata_i[16:9];

  // window check and address of the incoming item
  logic [7:0]        mn, mx, off;
  logic              tbl_ok, inwin, off_ok, remap_ok;
  logic [LIM_W-1:0]  size, lim;
  logic [ADDR_W-1:0] in_addr;
  status_e           remap_st;

  always_comb begin
    mn = 8'd0;
    mx = 8'd127;
    if (int'(in_tsel) < CFG_TABLES) begin
      mn = win_min_q[in_tsel];
      mx = win_max_q[in_tsel];
    end
    tbl_ok  = int'(in_tsel) < NUM_TABLES;
    inwin   = (in_kc >= mn) && (in_kc <= mx);
    off     = inwin ? (in_kc - mn) : 8'd0;
    off_ok  = int'(off) < TABLE_DEPTH;
    in_addr = ADDR_W'(int'(in_tsel) * TABLE_DEPTH + int'(off));
    if (!inwin || !off_ok) begin
      remap_st = ST_WINDOW;
    end else if (int'(in_adb) >= ADB_LIMIT) begin
      remap_st = ST_ADB;
    end else begin
      remap_st = ST_OK;
    end
    remap_ok = tbl_ok && (in_op == OP_REMAP) && (remap_st == ST_OK);
    size     = (mn <= mx) ? ({1'b0, mx} - {1'b0, mn} + LIM_W'(1)) : '0;
    lim      = (int'(size) > TABLE_DEPTH) ? LIM_W'(TABLE_DEPTH) : size;
  end

  assign sts_o.go_load = (in_op == OP_LOAD) && tbl_ok && (lim != '0);

  // captured item
  op_e              op_q;
  logic [1:0]       tsel_q;
  logic [7:0]       kc_q;
  logic             press_q, tbl_ok_q, inwin_q, off_ok_q;
  status_e          remap_st_q;
  logic [LIM_W-1:0] lim_q, idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_op;
      tsel_q     <= in_tsel;
      kc_q       <= in_kc;
      press_q    <= in_press;
      tbl_ok_q   <= tbl_ok;
      inwin_q    <= inwin;
      off_ok_q   <= off_ok;
      remap_st_q <= remap_st;
      lim_q      <= lim;
      idx_q      <= '0;
    end else if (cmd_i.load_step) begin
      idx_q <= idx_q + LIM_W'(1);
    end
  end

  assign sts_o.load_last = (idx_q + LIM_W'(1)) == lim_q;

  // default-table fill value
  logic [7:0] load_val;

  always_comb begin
    if (idx_q[LIM_W-1:7] != '0) begin
      load_val = KEY_UNMAPPED;
    end else if (linux_q) begin
      load_val = DEFAULT_ROM[idx_q[6:0]];
    end else begin
      load_val = {1'b0, idx_q[6:0]};
    end
  end

  // translation store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  always_comb begin
    if (cmd_i.load_step) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(int'(tsel_q) * TABLE_DEPTH + int'(idx_q));
      ram_wdata = load_val;
    end else begin
      ram_we    = cmd_i.capture && remap_ok;
      ram_waddr = in_addr;
      ram_wdata = in_adb;
    end
  end

  kts_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.capture),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  // result evaluation and held-key update
  logic [127:0] held_q, held_d;
  logic [7:0]   entry;
  logic [6:0]   code;
  logic         held, caps, act, emit;
  logic [7:0]   ev;
  status_e      st;

  always_comb begin
    held_d = held_q;
    entry  = off_ok_q ? ram_rdata : KEY_UNMAPPED;
    code   = entry[6:0] & CODE_MASK;
    held   = held_q[code];
    caps   = !osx_q && (code == CAPS_CODE);
    act    = caps ? !held : press_q;
    emit   = 1'b0;
    ev     = 8'd0;
    st     = ST_OK;
    priority if (op_q == OP_NONE) begin
      st = ST_OK;
    end else if (!tbl_ok_q) begin
      st = ST_WINDOW;
    end else if (op_q == OP_KEY) begin
      if (entry == KEY_UNMAPPED) begin
        st = ST_UNMAPPED;
      end else begin
        st = inwin_q ? ST_OK : ST_WINDOW;
        if (!(caps && !press_q)) begin
          if (act && !held) begin
            emit         = 1'b1;
            ev           = {1'b0, code};
            held_d[code] = 1'b1;
          end else if (!act && held) begin
            emit         = 1'b1;
            ev           = {1'b0, code} | RELEASE_BIT;
            held_d[code] = 1'b0;
          end
        end
      end
    end else if (op_q == OP_REMAP) begin
      st = remap_st_q;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.fire) begin
      held_q <= held_d;
    end
  end

  // output register
  logic       m_valid_q;
  logic [7:0] ev_q, raw_q;
  logic       emit_q;
  status_e    st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.fire) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      emit_q <= emit;
      ev_q   <= ev;
      raw_q  <= emit ? kc_q : 8'd0;
      st_q   <= st;
    end
  end

  assign sts_o.out_free = !m_valid_q || m_tready_i;
  assign m_tvalid_o     = m_valid_q;
  assign m_tdata_o      = {raw_q, ev_q};
  assign m_tuser_o      = {st_q, emit_q};

endmodule

// ----- design/keycode_translate_with_key_state_unit.sv -----
// Sequencing: a key event, remap write or ignored item is captured and read from the store
//   on acceptance, then evaluated into the output register once that register is free; a
//   default-table load first writes N entries, N = min(max - min + 1, TABLE_DEPTH), one
//   store write per cycle through the single write port.
// Flow: a new item is accepted only once the previous result has entered the output
//   register; the next item is taken while the result beat still waits there.
// Reset: windows, mode bits and held-key map return to defaults; store is undefined.
module keycode_translate_with_key_state_unit
  import kts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  // input stream
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [23:0]          s_tdata_i,  // keycode[7:0], is_press[8], adb_code[16:9], zero
  input  logic [3:0]           s_tuser_i,  // operation[1:0], table_select[3:2]
  // result stream
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [15:0]          m_tdata_o,  // event_code[7:0], host_keycode[15:8]
  output logic [2:0]           m_tuser_o   // emitted[0], status[2:1]
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence each item: accept and read the store, optionally sweep a default
  // table, then evaluate and drop the result beat into the output register.
  kts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Hold configuration, the translation store, held-key map and result beat.
  kts_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  assign s_tready_o = cmd.in_ready;

endmodule

// ----- tb/tb_keycode_translate_with_key_state_unit.sv -----
`timescale 1ns / 1ps

module tb_keycode_translate_with_key_state_unit;
  import kts_pkg::*;

  // One item offered on the input stream.
  typedef struct packed {
    op_e        op;
    logic [1:0] tsel;
    logic [7:0] keycode;
    logic       is_press;
    logic [7:0] adb_code;
  } key_item_t;

  // One result beat as the host sees it.
  typedef struct packed {
    logic       emitted;
    logic [7:0] event_code;
    logic [7:0] host_keycode;
    logic [1:0] status;
  } key_event_t;

  localparam int HOLD_OFF_CYCLES = 100;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 80;
  // Slowest legal item is a full-table load, with one store write per entry.
  localparam int SETTLE_CYCLES   = TABLE_DEPTH + 12;

  // Predicts every result beat and compares it with what the block sends.
  class keymap_scoreboard;
    logic [7:0] store [STORE_DEPTH];
    bit         held [128];
    logic [7:0] win_lo [NUM_TABLES];
    logic [7:0] win_hi [NUM_TABLES];
    bit         linux_default;
    bit         osx;
    key_event_t expected_q [$];
    int         fails;

    function new();
      foreach (store[i]) store[i] = '0;
      foreach (held[i]) held[i] = 1'b0;
      foreach (win_lo[i]) begin
        win_lo[i] = 8'd0;
        win_hi[i] = 8'd127;
      end
      linux_default = 1'b1;
      osx           = 1'b0;
      fails         = 0;
    endfunction

    function void set_reg(reg_e idx, logic [7:0] val);
      case (idx)
        REG_T0_MIN: win_lo[0] = val;
        REG_T0_MAX: win_hi[0] = val;
        REG_T1_MIN: win_lo[1] = val;
        REG_T1_MAX: win_hi[1] = val;
        REG_T2_MIN: win_lo[2] = val;
        REG_T2_MAX: win_hi[2] = val;
        REG_LINUX:  linux_default = val[0];
        REG_OSX:    osx = val[0];
        default:    ;
      endcase
    endfunction

    // Apply one item to the shadow tables and held-key map; return its beat.
    function key_event_t translate_item(key_item_t it);
      key_event_t  r;
      int unsigned lo, hi, off, base, span, i;
      bit          in_win, act, skip;
      logic [7:0]  entry;
      logic [6:0]  code;
      r.emitted      = 1'b0;
      r.event_code   = '0;
      r.host_keycode = '0;
      r.status       = ST_OK;
      if (it.op == OP_NONE) return r;
      if (it.tsel >= NUM_TABLES) begin
        r.status = ST_WINDOW;
        return r;
      end
      lo     = win_lo[it.tsel];
      hi     = win_hi[it.tsel];
      base   = it.tsel * TABLE_DEPTH;
      in_win = (it.keycode >= lo) && (it.keycode <= hi);
      case (it.op)
        OP_KEY: begin
          // Out-of-window keys fall back to the first entry of the table.
          off   = in_win ? it.keycode - lo : 0;
          entry = (off < TABLE_DEPTH) ? store[base + off] : KEY_UNMAPPED;
          if (entry == KEY_UNMAPPED) begin
            r.status = ST_UNMAPPED;
          end else begin
            code     = entry[6:0];
            act      = it.is_press;
            skip     = 1'b0;
            r.status = in_win ? ST_OK : ST_WINDOW;
            // Legacy caps lock: drop releases, toggle on every press.
            if (!osx && code == CAPS_CODE) begin
              if (!it.is_press) skip = 1'b1;
              else act = !held[code];
            end
            if (!skip) begin
              if (act && !held[code]) begin
                held[code]     = 1'b1;
                r.emitted      = 1'b1;
                r.event_code   = {1'b0, code};
                r.host_keycode = it.keycode;
              end else if (!act && held[code]) begin
                held[code]     = 1'b0;
                r.emitted      = 1'b1;
                r.event_code   = {1'b0, code} | RELEASE_BIT;
                r.host_keycode = it.keycode;
              end
            end
          end
        end
        OP_REMAP: begin
          if (!in_win || (it.keycode - lo) >= TABLE_DEPTH) r.status = ST_WINDOW;
          else if (it.adb_code >= ADB_LIMIT) r.status = ST_ADB;
          else store[base + it.keycode - lo] = it.adb_code;
        end
        OP_LOAD: begin
          if (lo <= hi) begin
            span = hi - lo + 1;
            for (i = 0; i < span && i < TABLE_DEPTH; i++) begin
              if (i >= 128) store[base + i] = KEY_UNMAPPED;
              else if (linux_default) store[base + i] = DEFAULT_ROM[i];
              else store[base + i] = 8'(i);
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(key_item_t it);
      expected_q.push_back(translate_item(it));
    endfunction

    function void check_result(key_event_t got);
      key_event_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: emitted=%0d event_code=%02h key=%02h",
               got.emitted, got.event_code, got.host_keycode);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (got.emitted !== want.emitted) begin
        $error("emitted: expected %0d, got %0d", want.emitted, got.emitted);
        fails++;
      end
      if (got.event_code !== want.event_code) begin
        $error("event_code: expected %02h, got %02h", want.event_code, got.event_code);
        fails++;
      end
      if (got.host_keycode !== want.host_keycode) begin
        $error("host_keycode: expected %02h, got %02h", want.host_keycode,
               got.host_keycode);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Count whatever is still owed at the end as a failure.
    function void close_out();
      if (expected_q.size() != 0) begin
        $error("%0d result beats never arrived", expected_q.size());
        fails += expected_q.size();
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [7:0]           cfg_wdata_i = '0;
  logic                 s_tvalid_i  = 1'b0;
  logic                 s_tready_o;
  logic [23:0]          s_tdata_i   = '0;  // keycode[7:0], is_press[8], adb_code[16:9], zero
  logic [3:0]           s_tuser_i   = '0;  // operation[1:0], table_select[3:2]
  logic                 m_tvalid_o;
  logic                 m_tready_i  = 1'b0;
  logic [15:0]          m_tdata_o;         // event_code[7:0], host_keycode[15:8]
  logic [2:0]           m_tuser_o;         // emitted[0], status[2:1]

  keymap_scoreboard sb;
  int unsigned      burst_left   = 0;
  bit               hold_off_req = 1'b0;
  logic [7:0]       key_pool [10];

  keycode_translate_with_key_state_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond a run where every item is a full-table load and
  // every beat waits out the longest stall.
  initial begin
    #8_000_000;
    $display("keycode_translate_with_key_state_unit regression: fail");
    $finish;
  end

  // Result sink: alternate stretches of always-ready, coin-flip ready and a
  // one-in-three pattern; on request hold ready low for a long fixed stretch.
  initial begin : result_sink
    int unsigned mode, run_len, tick;
    mode    = 0;
    run_len = 0;
    tick    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (run_len == 0) begin
          mode    = $urandom_range(0, 2);
          run_len = $urandom_range(5, 40);
        end
        run_len--;
        tick++;
        case (mode)
          0:       m_tready_i <= 1'b1;
          1:       m_tready_i <= 1'($urandom);
          default: m_tready_i <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Capture every accepted result beat.
  always @(posedge clk_i) begin : result_capture
    key_event_t got;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.emitted      = m_tuser_o[0];
      got.event_code   = m_tdata_o[7:0];
      got.host_keycode = m_tdata_o[15:8];
      got.status       = m_tuser_o[2:1];
      sb.check_result(got);
    end
  end

  function automatic key_item_t make_item(op_e op, logic [1:0] tsel, logic [7:0] kc,
                                          logic press, logic [7:0] adb);
    key_item_t it;
    it.op       = op;
    it.tsel     = tsel;
    it.keycode  = kc;
    it.is_press = press;
    it.adb_code = adb;
    return it;
  endfunction

  // Pack the eight register values in index order.
  function automatic logic [7:0][7:0] window_plan(logic [7:0] t0lo, logic [7:0] t0hi,
                                                  logic [7:0] t1lo, logic [7:0] t1hi,
                                                  logic [7:0] t2lo, logic [7:0] t2hi,
                                                  logic [7:0] linux, logic [7:0] osx);
    logic [7:0][7:0] p;
    p[REG_T0_MIN] = t0lo;
    p[REG_T0_MAX] = t0hi;
    p[REG_T1_MIN] = t1lo;
    p[REG_T1_MAX] = t1hi;
    p[REG_T2_MIN] = t2lo;
    p[REG_T2_MAX] = t2hi;
    p[REG_LINUX]  = linux;
    p[REG_OSX]    = osx;
    return p;
  endfunction

  function automatic logic [7:0] pick_bound();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Keys are drawn mostly from a small pool so that presses and releases
  // land on held state; caps lock in both its raw and identity codes.
  function automatic void refill_key_pool(logic [7:0] lo);
    int i;
    key_pool[0] = 8'd58;
    key_pool[1] = 8'(CAPS_LOCK_CODE);
    for (i = 2; i < 10; i++)
      key_pool[i] = (i < 6) ? 8'(lo + $urandom_range(0, 40)) : 8'($urandom);
  endfunction

  function automatic key_item_t random_item();
    key_item_t   it;
    int unsigned pick;
    pick        = $urandom_range(0, 99);
    it.tsel     = ($urandom_range(0, 19) == 0) ? 2'(NUM_TABLES)
                                               : 2'($urandom_range(0, NUM_TABLES - 1));
    it.keycode  = ($urandom_range(0, 5) == 0) ? 8'($urandom) : key_pool[$urandom_range(0, 9)];
    it.is_press = 1'($urandom);
    it.adb_code = 8'($urandom);
    if (pick < 74) begin
      it.op = OP_KEY;
    end else if (pick < 90) begin
      it.op = OP_REMAP;
      if ($urandom_range(0, 3) != 0) it.adb_code = 8'($urandom_range(0, ADB_LIMIT - 1));
    end else if (pick < 95) begin
      it.op = OP_LOAD;
    end else begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  // Offer one beat; bursts of random length separated by random gaps.
  // Valid stays high across back-to-back beats.
  task automatic send_item(input key_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {7'b0, it.adb_code, it.is_press, it.keycode};
    s_tuser_i  <= {it.tsel, it.op};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_input(it);
  endtask

  // Drop valid and hold until every predicted beat has come back.
  task automatic wait_results();
    s_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all eight registers, one per cycle, while the block is idle.
  task automatic write_registers(input logic [7:0][7:0] plan);
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= reg_e'(i);
      cfg_wdata_i <= plan[i];
      @(posedge clk_i);
      sb.set_reg(reg_e'(i), plan[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0][7:0] plan;
    logic [7:0]      lo, hi, swap;
    key_item_t       it;
    int              phase, n, t, guard;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-width windows first: loading every table writes all entries, so no
    // later key event can read a store entry that was never written.
    write_registers(window_plan(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd0));
    send_item(make_item(OP_LOAD, 2'd0, 8'd0, 1'b0, 8'h00));
    send_item(make_item(OP_LOAD, 2'd1, 8'hff, 1'b1, 8'hff));
    send_item(make_item(OP_LOAD, 2'd2, 8'd0, 1'b0, 8'h00));
    // Press, repeated press, release, repeated release.
    send_item(make_item(OP_KEY, 2'd0, 8'd2, 1'b1, 8'h00));
    send_item(make_item(OP_KEY, 2'd0, 8'd2, 1'b1, 8'h00));
    send_item(make_item(OP_KEY, 2'd0, 8'd2, 1'b0, 8'h00));
    send_item(make_item(OP_KEY, 2'd0, 8'd2, 1'b0, 8'h00));
    // Legacy caps lock: press toggles on, press toggles off, release ignored.
    send_item(make_item(OP_KEY, 2'd0, 8'd58, 1'b1, 8'h00));
    send_item(make_item(OP_KEY, 2'd0, 8'd58, 1'b1, 8'h00));
    send_item(make_item(OP_KEY, 2'd0, 8'd58, 1'b0, 8'h00));
    // Unmapped entries at both ends of the key range.
    send_item(make_item(OP_KEY, 2'd0, 8'd0, 1'b1, 8'h00));
    send_item(make_item(OP_KEY, 2'd0, 8'd255, 1'b1, 8'hff));
    // Remap at the top legal code, then a code that is too large.
    send_item(make_item(OP_REMAP, 2'd1, 8'd5, 1'b0, 8'd127));
    send_item(make_item(OP_REMAP, 2'd1, 8'd6, 1'b1, 8'd128));
    send_item(make_item(OP_KEY, 2'd1, 8'd5, 1'b1, 8'h00));
    // Table select past the last table, and the unused operation.
    send_item(make_item(OP_KEY, 2'(NUM_TABLES), 8'd2, 1'b1, 8'h00));
    send_item(make_item(OP_NONE, 2'd0, 8'd2, 1'b1, 8'h00));
    wait_results();

    // Narrow windows, an inverted one, identity default and OS X mode.
    write_registers(window_plan(8'd16, 8'd80, 8'd0, 8'd127, 8'd200, 8'd10, 8'd0, 8'd1));
    send_item(make_item(OP_KEY, 2'd0, 8'd5, 1'b1, 8'h00));
    send_item(make_item(OP_LOAD, 2'd1, 8'd0, 1'b0, 8'h00));
    send_item(make_item(OP_KEY, 2'd1, 8'd200, 1'b1, 8'h00));
    send_item(make_item(OP_KEY, 2'd1, 8'(CAPS_LOCK_CODE), 1'b1, 8'h00));
    send_item(make_item(OP_KEY, 2'd1, 8'(CAPS_LOCK_CODE), 1'b0, 8'h00));
    send_item(make_item(OP_REMAP, 2'd0, 8'd5, 1'b0, 8'd3));
    send_item(make_item(OP_LOAD, 2'd2, 8'd0, 1'b0, 8'h00));
    send_item(make_item(OP_KEY, 2'd2, 8'd100, 1'b1, 8'h00));
    send_item(make_item(OP_REMAP, 2'd2, 8'd100, 1'b1, 8'd1));
    wait_results();

    for (phase = 0; phase < PHASES; phase++) begin
      for (t = 0; t < NUM_TABLES; t++) begin
        lo = pick_bound();
        hi = pick_bound();
        // Keep most windows well-formed; leave some inverted.
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        plan[2 * t]     = lo;
        plan[2 * t + 1] = hi;
      end
      plan[REG_LINUX] = {7'($urandom), 1'($urandom)};
      plan[REG_OSX]   = {7'($urandom), 1'($urandom)};
      if (phase == 0) plan = window_plan(8'd0, 8'd255, 8'd255, 8'd255, 8'd128, 8'd0,
                                         8'd0, 8'd1);
      write_registers(plan);
      refill_key_pool(plan[2 * $urandom_range(0, NUM_TABLES - 1)]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (phase == 1 && n == 20) hold_off_req = 1'b1;
        if (phase == 3 && n == 40) wait_results();
        it = random_item();
        send_item(it);
        // Ignored items do not advance the phase.
        if (it.op != OP_NONE && it.tsel < NUM_TABLES) n++;
      end
      wait_results();
    end

    // Drain with a bound, then watch for stray beats over one full load time.
    s_tvalid_i <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20 * SETTLE_CYCLES) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.close_out();
    if (sb.fails == 0)
      $display("keycode_translate_with_key_state_unit regression: pass");
    else
      $display("keycode_translate_with_key_state_unit regression: fail");
    $finish;
  end

endmodule
